FILE: rtl/iapf_pkg.sv
// Shared constants, types and the CORDIC turn table for the attitude frame parser.
// No dependencies.
package iapf_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_QUAT  = 8'h59;

    localparam logic [2:0] ST_ANGLE   = 3'd0;
    localparam logic [2:0] ST_QUAT    = 3'd1;
    localparam logic [2:0] ST_BADSUM  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_SKIP    = 3'd4;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 36;

    typedef struct packed {
        logic        last_byte;
        logic        done;
        logic        sum_ok;
        logic [7:0]  ftype;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } quat_ang_t;

    function automatic logic [31:0] turn_step(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/iapf_frame.sv
// Header hunt, byte shift register and running checksum for one 11-byte frame.
// Depends on iapf_pkg.
module iapf_frame
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output iapf_pkg::frame_t     frame
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] sr_reg [10];
    logic [7:0] sr_next [10];
    logic       store;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        sr_next  = sr_reg;
        store    = 1'b0;
        if (accept)
        begin
            if (pos_reg == 4'd0)
            begin
                if (rx_byte == iapf_pkg::HDR_BYTE)
                begin
                    store    = 1'b1;
                    pos_next = 4'd1;
                    sum_next = rx_byte;
                end
            end
            else if (pos_reg == 4'd10)
            begin
                pos_next = 4'd0;
            end
            else
            begin
                store    = 1'b1;
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + rx_byte;
            end
        end
        if (store)
        begin
            for (int i = 0; i < 9; i++)
            begin
                sr_next[i] = sr_reg[i + 1];
            end
            sr_next[9] = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        sr_reg  <= sr_next;
    end

    always_comb
    begin
        frame.last_byte = (pos_reg == 4'd10);
        frame.done      = accept && (pos_reg == 4'd10);
        frame.sum_ok    = (sum_reg == rx_byte);
        frame.ftype     = sr_reg[1];
        frame.w0        = {sr_reg[3], sr_reg[2]};
        frame.w1        = {sr_reg[5], sr_reg[4]};
        frame.w2        = {sr_reg[7], sr_reg[6]};
        frame.w3        = {sr_reg[9], sr_reg[8]};
    end

endmodule

FILE: rtl/iapf_unwrap.sv
// Wrapped 16-bit difference against the previous angle, added with saturation.
// No dependencies.
module iapf_unwrap
#(
    parameter int W = 32
)
(
    input  logic signed [W-1:0] last,
    input  logic signed [15:0]  ang,
    output logic signed [W-1:0] result
);

    logic signed [15:0] d;
    logic        [W:0]  sum;
    logic               ovf;

    always_comb
    begin
        d      = ang - last[15:0];
        sum    = {last[W-1], last} + {{(W - 15){d[15]}}, d};
        ovf    = sum[W] ^ sum[W-1];
        if (ovf)
        begin
            result = d[15] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end
        else
        begin
            result = sum[W-1:0];
        end
    end

endmodule

FILE: rtl/iapf_cordic.sv
// Iterative vectoring CORDIC, one rotation per cycle, giving a 16-bit angle.
// Depends on iapf_pkg.
module iapf_cordic
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [iapf_pkg::CW-1:0]    y_in,
    input  logic signed [iapf_pkg::CW-1:0]    x_in,
    output logic                              done,
    output logic signed [15:0]                angle
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           zero_reg, zero_next;
    logic [4:0]                     i_reg, i_next;
    logic signed [iapf_pkg::CW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic [31:0]                    z_reg, z_next, z_rnd;
    logic signed [15:0]             angle_reg, angle_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        i_next     = i_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        angle_next = angle_reg;
        dx         = y_reg >>> i_reg;
        dy         = x_reg >>> i_reg;
        z_rnd      = 32'h0;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = 5'd0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in[iapf_pkg::CW-1])
            begin
                x_next = -x_in;
                y_next = -y_in;
                z_next = 32'h8000_0000;
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = 32'h0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[iapf_pkg::CW-1] && (y_reg != '0))
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + iapf_pkg::turn_step(i_reg);
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - iapf_pkg::turn_step(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(iapf_pkg::CORDIC_STEPS - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                z_rnd      = z_next + 32'h8000;
                angle_next = zero_reg ? 16'sd0 : z_rnd[31:16];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg  <= zero_next;
        i_reg     <= i_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: rtl/iapf_quat.sv
// Quaternion to Euler sequencer: bit-serial products, bit-serial square, root, CORDIC.
// Depends on iapf_pkg and iapf_cordic.
module iapf_quat
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [15:0]   qa,
    input  logic signed [15:0]   qb,
    input  logic signed [15:0]   qc,
    input  logic signed [15:0]   qd,
    output logic                 done,
    output iapf_pkg::quat_ang_t  ang
);

    typedef enum logic [5:0] {
        Q_IDLE = 6'b000001,
        Q_MUL  = 6'b000010,
        Q_FORM = 6'b000100,
        Q_SQ   = 6'b001000,
        Q_ROOT = 6'b010000,
        Q_ANG  = 6'b100000
    } qstate_t;

    localparam logic signed [33:0] ONE = 34'sd1 << 30;

    qstate_t            state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [3:0]         k_reg, k_next, k_sel;
    logic [1:0]         j_reg, j_next;
    logic signed [31:0] acc_reg, acc_next, msh_reg, msh_next, addend, acc_sum;
    logic [15:0]        mq_reg, mq_next;
    logic signed [15:0] op_a, op_b;
    logic signed [31:0] prod_reg [9];
    logic signed [31:0] prod_next [9];
    logic signed [33:0] ry_reg, ry_next, rx_reg, rx_next, yy_reg, yy_next;
    logic signed [33:0] yx_reg, yx_next, s_reg, s_next, s_raw;
    logic [30:0]        sq_reg, sq_next;
    logic [61:0]        sacc_reg, sacc_next, ssh_reg, ssh_next, sacc_sum;
    logic [61:0]        nrem_reg, nrem_next, root_reg, root_next, rbit_reg, rbit_next;
    logic [61:0]        trial;
    logic               cst_reg, cst_next, done_reg, done_next;
    iapf_pkg::quat_ang_t ang_reg, ang_next;
    logic signed [iapf_pkg::CW-1:0] c_y, c_x;
    logic               c_done;
    logic signed [15:0] c_angle;

    always_comb
    begin
        k_sel = (state_reg == Q_IDLE) ? 4'd0 : k_reg + 4'd1;
        case (k_sel)
            4'd0:    begin op_a = qa; op_b = qb; end
            4'd1:    begin op_a = qc; op_b = qd; end
            4'd2:    begin op_a = qb; op_b = qb; end
            4'd3:    begin op_a = qc; op_b = qc; end
            4'd4:    begin op_a = qa; op_b = qc; end
            4'd5:    begin op_a = qd; op_b = qb; end
            4'd6:    begin op_a = qa; op_b = qd; end
            4'd7:    begin op_a = qb; op_b = qc; end
            4'd8:    begin op_a = qd; op_b = qd; end
            default: begin op_a = 16'sd0; op_b = 16'sd0; end
        endcase
    end

    always_comb
    begin
        case (j_reg)
            2'd0:    begin c_y = iapf_pkg::CW'(ry_reg); c_x = iapf_pkg::CW'(rx_reg); end
            2'd1:    begin c_y = iapf_pkg::CW'(s_reg);
                           c_x = iapf_pkg::CW'(root_reg[30:0]); end
            default: begin c_y = iapf_pkg::CW'(yy_reg); c_x = iapf_pkg::CW'(yx_reg); end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        acc_next   = acc_reg;
        msh_next   = msh_reg;
        mq_next    = mq_reg;
        prod_next  = prod_reg;
        ry_next    = ry_reg;
        rx_next    = rx_reg;
        yy_next    = yy_reg;
        yx_next    = yx_reg;
        s_next     = s_reg;
        sq_next    = sq_reg;
        sacc_next  = sacc_reg;
        ssh_next   = ssh_reg;
        nrem_next  = nrem_reg;
        root_next  = root_reg;
        rbit_next  = rbit_reg;
        cst_next   = 1'b0;
        done_next  = 1'b0;
        ang_next   = ang_reg;
        addend     = mq_reg[0] ? ((cnt_reg == 5'd15) ? -msh_reg : msh_reg) : 32'sd0;
        acc_sum    = acc_reg + addend;
        sacc_sum   = sacc_reg + (sq_reg[0] ? ssh_reg : 62'd0);
        trial      = root_reg + rbit_reg;
        s_raw      = (34'(prod_reg[4]) - 34'(prod_reg[5])) <<< 1;
        case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    state_next = Q_MUL;
                    cnt_next   = 5'd0;
                    k_next     = 4'd0;
                    acc_next   = 32'sd0;
                    msh_next   = 32'(op_a);
                    mq_next    = op_b;
                end
            end
            Q_MUL:
            begin
                acc_next = acc_sum;
                msh_next = msh_reg <<< 1;
                mq_next  = mq_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    prod_next[k_reg] = acc_sum;
                    cnt_next         = 5'd0;
                    if (k_reg == 4'd8)
                    begin
                        state_next = Q_FORM;
                    end
                    else
                    begin
                        k_next   = k_reg + 4'd1;
                        acc_next = 32'sd0;
                        msh_next = 32'(op_a);
                        mq_next  = op_b;
                    end
                end
            end
            Q_FORM:
            begin
                ry_next = (34'(prod_reg[0]) + 34'(prod_reg[1])) <<< 1;
                rx_next = ONE - ((34'(prod_reg[2]) + 34'(prod_reg[3])) <<< 1);
                yy_next = (34'(prod_reg[6]) + 34'(prod_reg[7])) <<< 1;
                yx_next = ONE - ((34'(prod_reg[3]) + 34'(prod_reg[8])) <<< 1);
                if (s_raw > ONE)
                begin
                    s_next = ONE;
                end
                else if (s_raw < -ONE)
                begin
                    s_next = -ONE;
                end
                else
                begin
                    s_next = s_raw;
                end
                sq_next    = s_next[33] ? 31'(-s_next) : 31'(s_next);
                ssh_next   = {31'd0, sq_next};
                sacc_next  = 62'd0;
                cnt_next   = 5'd0;
                state_next = Q_SQ;
            end
            Q_SQ:
            begin
                sacc_next = sacc_sum;
                ssh_next  = ssh_reg << 1;
                sq_next   = sq_reg >> 1;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    nrem_next  = (62'd1 << 60) - sacc_sum;
                    root_next  = 62'd0;
                    rbit_next  = 62'd1 << 60;
                    cnt_next   = 5'd0;
                    state_next = Q_ROOT;
                end
            end
            Q_ROOT:
            begin
                if (nrem_reg >= trial)
                begin
                    nrem_next = nrem_reg - trial;
                    root_next = (root_reg >> 1) + rbit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    state_next = Q_ANG;
                    j_next     = 2'd0;
                    cst_next   = 1'b1;
                end
            end
            Q_ANG:
            begin
                if (c_done)
                begin
                    case (j_reg)
                        2'd0:    ang_next.roll  = c_angle;
                        2'd1:    ang_next.pitch = c_angle;
                        default: ang_next.yaw   = c_angle;
                    endcase
                    if (j_reg == 2'd2)
                    begin
                        done_next  = 1'b1;
                        state_next = Q_IDLE;
                    end
                    else
                    begin
                        j_next   = j_reg + 2'd1;
                        cst_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    iapf_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cst_reg),
        .y_in  (c_y),
        .x_in  (c_x),
        .done  (c_done),
        .angle (c_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            cst_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cst_reg   <= cst_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        acc_reg  <= acc_next;
        msh_reg  <= msh_next;
        mq_reg   <= mq_next;
        prod_reg <= prod_next;
        ry_reg   <= ry_next;
        rx_reg   <= rx_next;
        yy_reg   <= yy_next;
        yx_reg   <= yx_next;
        s_reg    <= s_next;
        sq_reg   <= sq_next;
        sacc_reg <= sacc_next;
        ssh_reg  <= ssh_next;
        nrem_reg <= nrem_next;
        root_reg <= root_next;
        rbit_reg <= rbit_next;
        ang_reg  <= ang_next;
    end

    assign done = done_reg;
    assign ang  = ang_reg;

endmodule

FILE: rtl/imu_attitude_frame_parser_top.sv
// Top level of the attitude frame parser: framing, output register, unwrap state.
// Depends on iapf_pkg, iapf_frame, iapf_quat, iapf_unwrap.
//
// Input channel: one serial byte per request (in_valid, in_stall, rx_byte).
// Bytes are hunted for the 0x55 header and gathered into 11-byte frames.
// Only the eleventh byte of a frame produces a result request on the output
// channel (out_valid, out_stall); all other bytes produce nothing.
// Angle frames and rejected frames load the output register in the cycle after
// the eleventh byte; quaternion frames are first converted by nine serial
// products, a serial square, a 31-step square root and three CORDIC runs,
// all run one after another by one sequencer.
// Bytes 1 to 10 are taken every cycle; while a quaternion frame is being
// converted in_stall is high.
// A finished result sits in the output register; further bytes are taken
// while it waits, but the eleventh byte of the next frame is stalled until
// the receiver has taken it.
// Reset returns to header hunting, clears the unwrap history and the
// quaternion mode latch.
module imu_attitude_frame_parser_top
#(
    parameter int UNWRAP_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [31:0] yaw_angle,
    output logic               quaternion_mode
);

    typedef enum logic [1:0] {
        T_RUN  = 2'b01,
        T_CALC = 2'b10
    } tstate_t;

    tstate_t                       state_reg, state_next;
    iapf_pkg::frame_t              frame;
    iapf_pkg::quat_ang_t           q_ang;
    logic                          accept, q_start, q_done, load;
    logic signed [UNWRAP_WIDTH-1:0] lroll_reg, lroll_next, lyaw_reg, lyaw_next;
    logic signed [UNWRAP_WIDTH-1:0] roll_uw, yaw_uw;
    logic signed [15:0]            roll_src, yaw_src;
    logic                          latch_reg, latch_next;
    logic                          ov_reg, ov_next;
    logic [2:0]                    st_reg, st_next;
    logic signed [31:0]            oroll_reg, oroll_next, oyaw_reg, oyaw_next;
    logic signed [15:0]            opitch_reg, opitch_next;
    logic                          oqm_reg, oqm_next;

    assign in_stall = (state_reg == T_CALC) || (ov_reg && frame.last_byte);
    assign accept   = in_valid && !in_stall;
    assign q_start  = frame.done && frame.sum_ok && (frame.ftype == iapf_pkg::TYPE_QUAT);

    iapf_frame u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    iapf_quat u_quat
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_start),
        .qa    (frame.w0),
        .qb    (frame.w1),
        .qc    (frame.w2),
        .qd    (frame.w3),
        .done  (q_done),
        .ang   (q_ang)
    );

    assign roll_src = (state_reg == T_CALC) ? q_ang.roll : frame.w0;
    assign yaw_src  = (state_reg == T_CALC) ? q_ang.yaw  : frame.w2;

    iapf_unwrap #(.W(UNWRAP_WIDTH)) u_unwrap_roll
    (
        .last   (lroll_reg),
        .ang    (roll_src),
        .result (roll_uw)
    );

    iapf_unwrap #(.W(UNWRAP_WIDTH)) u_unwrap_yaw
    (
        .last   (lyaw_reg),
        .ang    (yaw_src),
        .result (yaw_uw)
    );

    always_comb
    begin
        state_next  = state_reg;
        lroll_next  = lroll_reg;
        lyaw_next   = lyaw_reg;
        latch_next  = latch_reg;
        ov_next     = ov_reg;
        st_next     = st_reg;
        oroll_next  = oroll_reg;
        opitch_next = opitch_reg;
        oyaw_next   = oyaw_reg;
        oqm_next    = oqm_reg;
        load        = 1'b0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (frame.done)
        begin
            oroll_next  = 32'sd0;
            opitch_next = 16'sd0;
            oyaw_next   = 32'sd0;
            oqm_next    = latch_reg;
            if (!frame.sum_ok)
            begin
                load    = 1'b1;
                st_next = iapf_pkg::ST_BADSUM;
            end
            else if (frame.ftype == iapf_pkg::TYPE_QUAT)
            begin
                state_next = T_CALC;
            end
            else if (frame.ftype == iapf_pkg::TYPE_ANGLE)
            begin
                load = 1'b1;
                if (latch_reg)
                begin
                    st_next = iapf_pkg::ST_SKIP;
                end
                else
                begin
                    st_next     = iapf_pkg::ST_ANGLE;
                    lroll_next  = roll_uw;
                    lyaw_next   = yaw_uw;
                    oroll_next  = 32'(roll_uw);
                    opitch_next = frame.w1;
                    oyaw_next   = 32'(yaw_uw);
                end
            end
            else
            begin
                load    = 1'b1;
                st_next = iapf_pkg::ST_UNKNOWN;
            end
        end
        if ((state_reg == T_CALC) && q_done)
        begin
            load        = 1'b1;
            state_next  = T_RUN;
            st_next     = iapf_pkg::ST_QUAT;
            lroll_next  = roll_uw;
            lyaw_next   = yaw_uw;
            latch_next  = 1'b1;
            oroll_next  = 32'(roll_uw);
            opitch_next = q_ang.pitch;
            oyaw_next   = 32'(yaw_uw);
            oqm_next    = 1'b1;
        end
        if (load)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_RUN;
            lroll_reg <= '0;
            lyaw_reg  <= '0;
            latch_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lroll_reg <= lroll_next;
            lyaw_reg  <= lyaw_next;
            latch_reg <= latch_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        oroll_reg  <= oroll_next;
        opitch_reg <= opitch_next;
        oyaw_reg   <= oyaw_next;
        oqm_reg    <= oqm_next;
    end

    assign out_valid       = ov_reg;
    assign status          = st_reg;
    assign roll_angle      = oroll_reg;
    assign pitch_angle     = opitch_reg;
    assign yaw_angle       = oyaw_reg;
    assign quaternion_mode = oqm_reg;

    a_calc_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CALC) |-> in_stall)
        else $error("byte taken during quaternion conversion");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        q_done |-> (state_reg == T_CALC))
        else $error("conversion finished outside calc state");

    a_latch_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg |=> latch_reg)
        else $error("quaternion latch cleared");

    a_quat_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (st_reg == iapf_pkg::ST_QUAT)) |-> oqm_reg)
        else $error("quaternion result without quaternion mode");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!ov_reg || !out_stall))
        else $error("pending result overwritten");

endmodule

FILE: sim/imu_attitude_frame_parser_top_tb.sv
// Testbench for imu_attitude_frame_parser_top: drives framed serial bytes with bursts
// and gaps, predicts each frame result in SystemVerilog and checks it. Depends on iapf_pkg.
`timescale 1ns / 1ps

module imu_attitude_frame_parser_top_tb;

    localparam int UW = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [31:0] TURN [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    typedef struct packed {
        logic [2:0]         st;
        logic signed [31:0] roll;
        logic signed [15:0] pitch;
        logic signed [31:0] yaw;
        logic               qmode;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [2:0] status;
    logic signed [31:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [31:0] yaw_angle;
    logic quaternion_mode;

    attitude_t expected_q[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    // predictor state
    int unsigned pos = 0;
    logic [7:0] frame_buf [11];
    longint track_roll = 0;
    longint track_yaw = 0;
    bit quat_seen = 1'b0;

    always #1 clk = ~clk;

    imu_attitude_frame_parser_top #(.UNWRAP_WIDTH(UW)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .rx_byte(rx_byte), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .quaternion_mode(quaternion_mode));

    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [15:0] cordic_angle(longint y, longint x);
        logic [31:0] z = 32'h0;
        longint dx;
        longint dy;
        logic [31:0] t;
        if (x == 0 && y == 0)
            return 16'sd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = asr_floor(y, i);
            dy = asr_floor(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += TURN[i];
            end
            else
            begin
                x -= dx; y += dy; z -= TURN[i];
            end
        end
        t = z + 32'h8000;
        return t[31:16];
    endfunction

    function automatic longint unwrap_track(longint prev, logic signed [15:0] a);
        longint hi = (longint'(1) <<< (UW - 1)) - 1;
        longint lo = -hi - 1;
        logic [15:0] w = 16'(longint'(a) - prev);
        longint d = longint'($signed(w));
        if (d > 0 && prev > hi - d) return hi;
        if (d < 0 && prev < lo - d) return lo;
        return prev + d;
    endfunction

    function automatic longint word16(int k);
        return longint'($signed({frame_buf[k + 1], frame_buf[k]}));
    endfunction

    task automatic predict_byte(logic [7:0] b);
        attitude_t r;
        logic [7:0] sum = 8'h00;
        longint a, bq, c, d, s, cp;
        longint one = longint'(1) <<< 30;
        logic signed [15:0] ar, ap, ay;
        if (pos == 0 && b != iapf_pkg::HDR_BYTE)
            return;
        frame_buf[pos] = b;
        if (pos < 10)
        begin
            pos++;
            return;
        end
        pos = 0;
        r = '0;
        for (int k = 0; k < 10; k++)
            sum += frame_buf[k];
        if (sum != frame_buf[10])
            r.st = iapf_pkg::ST_BADSUM;
        else if (frame_buf[1] == iapf_pkg::TYPE_QUAT)
        begin
            a = word16(2); bq = word16(4); c = word16(6); d = word16(8);
            s = 2 * (a * c - d * bq);
            if (s > one) s = one;
            if (s < -one) s = -one;
            cp = isqrt((64'd1 << 60) - longint'(s * s));
            ar = cordic_angle(2 * (a * bq + c * d), one - 2 * (bq * bq + c * c));
            ap = cordic_angle(s, cp);
            ay = cordic_angle(2 * (a * d + bq * c), one - 2 * (c * c + d * d));
            track_roll = unwrap_track(track_roll, ar);
            track_yaw = unwrap_track(track_yaw, ay);
            quat_seen = 1'b1;
            r.st = iapf_pkg::ST_QUAT;
            r.roll = track_roll[31:0];
            r.pitch = ap;
            r.yaw = track_yaw[31:0];
        end
        else if (frame_buf[1] == iapf_pkg::TYPE_ANGLE)
        begin
            if (quat_seen)
                r.st = iapf_pkg::ST_SKIP;
            else
            begin
                track_roll = unwrap_track(track_roll, 16'(word16(2)));
                track_yaw = unwrap_track(track_yaw, 16'(word16(6)));
                r.st = iapf_pkg::ST_ANGLE;
                r.roll = track_roll[31:0];
                r.pitch = 16'(word16(4));
                r.yaw = track_yaw[31:0];
            end
        end
        else
            r.st = iapf_pkg::ST_UNKNOWN;
        r.qmode = quat_seen;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // one byte request; bursts with random gaps
    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b);
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_frame(logic [7:0] ftype, logic [15:0] w0, logic [15:0] w1,
                              logic [15:0] w2, logic [15:0] w3, bit corrupt);
        logic [7:0] f [11];
        logic [7:0] sum = 8'h00;
        f = '{iapf_pkg::HDR_BYTE, ftype, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
              w2[7:0], w2[15:8], w3[7:0], w3[15:8], 8'h00};
        for (int k = 0; k < 10; k++)
            sum += f[k];
        f[10] = corrupt ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum;
        for (int k = 0; k < 11; k++)
            send_byte(f[k]);
    endtask

    function automatic logic [15:0] rand_q15();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed_angle();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(iapf_pkg::TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
        send_frame(iapf_pkg::TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_ANGLE, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1);
        send_frame(8'hAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_frame(8'h55, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b0);
    endtask

    task automatic test_directed_quat();
        send_frame(iapf_pkg::TYPE_QUAT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_QUAT, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_QUAT, 16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_QUAT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
        send_frame(iapf_pkg::TYPE_QUAT, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_ANGLE, 16'h1111, 16'h2222, 16'h3333, 16'h0000, 1'b0);
        send_frame(iapf_pkg::TYPE_QUAT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    endtask

    task automatic test_random_stream(int n_frames, bit allow_angle);
        logic [7:0] ft;
        int sel;
        for (int n = 0; n < n_frames; n++)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                continue;
            end
            if (sel < 3)
                ft = 8'($urandom);
            else if (allow_angle && sel < 12)
                ft = iapf_pkg::TYPE_ANGLE;
            else
                ft = iapf_pkg::TYPE_QUAT;
            send_frame(ft, rand_q15(), rand_q15(), rand_q15(), rand_q15(),
                       $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random_stream(6, 1'b1);
        join
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_angle();
        test_random_stream(25, 1'b1);
        test_backpressure();
        test_directed_quat();
        test_random_stream(8, 1'b1);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 63) < 8)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            out_stall <= ($urandom_range(0, 2) == 0);
        else
            out_stall <= out_stall & ($urandom_range(0, 1) == 0);
    end

    always @(posedge clk)
    begin
        attitude_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result request", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.st) report_mismatch("status", status, want.st);
                if (roll_angle !== want.roll) report_mismatch("roll", roll_angle, want.roll);
                if (pitch_angle !== want.pitch)
                    report_mismatch("pitch", pitch_angle, want.pitch);
                if (yaw_angle !== want.yaw) report_mismatch("yaw", yaw_angle, want.yaw);
                if (quaternion_mode !== want.qmode)
                    report_mismatch("quaternion_mode", quaternion_mode, want.qmode);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule
